// File: rtl/spg_pkg.sv
// Shared types, constants and constant tables of the STFT power spectrogram block.
package spg_pkg;

  // Frame geometry
  localparam int FrameLen = 64;
  localparam int SampleW  = 16;
  localparam int HopLen   = FrameLen - FrameLen / 2;
  localparam int NumBins  = FrameLen / 2 + 1;
  localparam int IdxW     = $clog2(FrameLen);
  localparam int BinW     = 6;
  localparam int PowerW   = 43;

  // Sample memory holds two frames so new samples land outside the frame in work
  localparam int MemDepth = 2 * FrameLen;
  localparam int PtrW     = $clog2(MemDepth);
  localparam int FillW    = $clog2(FrameLen + 1);
  localparam int HopW     = $clog2(HopLen + 1);

  // Datapath widths
  localparam int WinW = 16;
  localparam int TwW  = 16;
  localparam int P1W  = SampleW + WinW + 1;
  localparam int XW   = SampleW + 2;
  localparam int PrW  = XW + TwW;
  localparam int AccW = 48;
  localparam int ReW  = 23;
  localparam int SqW  = 2 * ReW;
  localparam logic [PowerW-1:0] PowerMax = PowerW'(1) << 42;

  // Table generation constants (Q2.30)
  localparam longint Q30One = 64'sd1073741824;
  localparam longint Pi4Q30 = 64'sd843314857;
  localparam int     WinDiv = FrameLen - 1;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      restart;
  } in_item_t;

  typedef struct packed {
    logic [BinW-1:0]   bin;
    logic [PowerW-1:0] power;
    logic              last_bin;
  } out_item_t;

  typedef struct packed {
    logic                      en;
    logic [PtrW-1:0]           addr;
    logic signed [SampleW-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic            full;
    logic            empty;
    logic [PtrW-1:0] head;
  } q_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RUN,
    BK_DRAIN,
    BK_FIN1,
    BK_FIN2,
    BK_OUT
  } back_state_t;

  // cos and sin pair, Q2.30
  typedef struct packed {
    longint c;
    longint s;
  } cs_pair_t;

  typedef logic [WinW-1:0]       win_tab_t [FrameLen];
  typedef logic signed [TwW-1:0] tw_tab_t  [FrameLen];

  // truncating division by shift and subtract, for table generation
  function automatic longint qdiv(input longint n, input longint d);
    longint unsigned un, ud, q, rem;
    un  = (n < 0) ? 64'(-n) : 64'(n);
    ud  = (d < 0) ? 64'(-d) : 64'(d);
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], un[b]};
      if (rem >= ud) begin
        rem  = rem - ud;
        q[b] = 1'b1;
      end
    end
    return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint qrem(input longint n, input longint d);
    return n - qdiv(n, d) * d;
  endfunction

  // cos and sin (Q2.30) of phi in [0, pi/4] by Taylor series
  function automatic cs_pair_t taylor(input longint phi);
    longint   x2, tc, ts;
    cs_pair_t res;
    x2 = (phi * phi) / Q30One;
    tc = Q30One;
    ts = phi;
    res.c = 0;
    res.s = 0;
    for (int k = 1; k <= 10; k++) begin
      res.c += tc;
      res.s += ts;
      tc = -qdiv((tc * x2) / Q30One, longint'((2 * k - 1) * (2 * k)));
      ts = -qdiv((ts * x2) / Q30One, longint'((2 * k) * (2 * k + 1)));
    end
    return res;
  endfunction

  // unfold the first-octant result to the full circle
  function automatic cs_pair_t oct_map(input int unsigned oct, input cs_pair_t v);
    cs_pair_t m;
    unique case (oct % 8)
      0: begin m.c = v.c;  m.s = v.s;  end
      1: begin m.c = v.s;  m.s = v.c;  end
      2: begin m.c = -v.s; m.s = v.c;  end
      3: begin m.c = -v.c; m.s = v.s;  end
      4: begin m.c = -v.c; m.s = -v.s; end
      5: begin m.c = -v.s; m.s = -v.c; end
      6: begin m.c = v.s;  m.s = -v.c; end
      default: begin m.c = v.c; m.s = -v.s; end
    endcase
    return m;
  endfunction

  // Hamming coefficient, unsigned Q0.16
  function automatic logic [WinW-1:0] win_coef(input int unsigned i);
    int unsigned t, oct, r, a;
    longint      phi, w;
    cs_pair_t    cs;
    t   = 32'(qrem(longint'(i), WinDiv));
    oct = 32'(qdiv(longint'(8 * t), WinDiv));
    r   = 8 * t - oct * WinDiv;
    a   = (oct % 2 == 1) ? (WinDiv - r) : r;
    phi = qdiv(longint'(a) * Pi4Q30, WinDiv);
    cs  = oct_map(oct, taylor(phi));
    w = qdiv(54 * Q30One - 46 * cs.c + 50 * 64'sd16384, 100 * 64'sd16384);
    if (w > 65535) w = 65535;
    if (w < 0) w = 0;
    return WinW'(w);
  endfunction

  // Q2.30 to rounded, saturated Q1.15
  function automatic logic signed [TwW-1:0] to_q15(input longint v);
    longint r;
    r = (v + Q30One + 16384) / 32768 - 32768;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return TwW'(r);
  endfunction

  // twiddle cosine or sine of 2 pi i / FrameLen
  function automatic logic signed [TwW-1:0] tw_coef(input int unsigned i, input bit want_sin);
    int unsigned t, oct, r, a;
    longint      phi;
    cs_pair_t    cs;
    t   = i % FrameLen;
    oct = (8 * t) / FrameLen;
    r   = 8 * t - oct * FrameLen;
    a   = (oct % 2 == 1) ? (FrameLen - r) : r;
    phi = (longint'(a) * Pi4Q30) / FrameLen;
    cs  = oct_map(oct, taylor(phi));
    return want_sin ? to_q15(cs.s) : to_q15(cs.c);
  endfunction

  function automatic win_tab_t build_win();
    win_tab_t tab;
    for (int i = 0; i < FrameLen; i++) tab[i] = win_coef(i);
    return tab;
  endfunction

  function automatic tw_tab_t build_tw(input bit want_sin);
    tw_tab_t tab;
    for (int i = 0; i < FrameLen; i++) tab[i] = tw_coef(i, want_sin);
    return tab;
  endfunction

  localparam win_tab_t WinRom = build_win();
  localparam tw_tab_t  TwCos  = build_tw(1'b0);
  localparam tw_tab_t  TwSin  = build_tw(1'b1);

endpackage

// File: rtl/stft_power_spectrogram_top.sv
// STFT power spectrogram top level: front end, frame queue and transform back end.
// Samples enter one per cycle while the queue is not full and the two-frame sample memory has
// room; a full 64-sample frame, and every 32 samples after it, is posted to a two-entry queue.
// The back end computes one bin at a time with a single complex multiply-accumulate:
// accumulation over the frame's 64 samples, then pipeline drain, rounding and squaring, so
// throughput is set by the one MAC unit. Results leave through a registered output; bins
// 0..32 are given in order and last_bin marks bin 32. A restart drops the partial frame and
// restarts fill and hop counting.
module stft_power_spectrogram_top import spg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  q_stat_t         q_stat;
  mem_wr_t         mem_wr;
  logic            push, pop;
  logic [PtrW-1:0] push_ptr;

  spg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_stat   (q_stat),
    .push     (push),
    .push_ptr (push_ptr),
    .mem_wr   (mem_wr)
  );

  spg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ptr (push_ptr),
    .pop      (pop),
    .q_stat   (q_stat)
  );

  spg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mem_wr    (mem_wr),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// File: rtl/spg_front.sv
// Front end: takes samples, tracks frame fill and hop, posts finished frames.
module spg_front import spg_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  in_item_t        in_item,
  input  q_stat_t         q_stat,
  output logic            push,
  output logic [PtrW-1:0] push_ptr,
  output mem_wr_t         mem_wr
);

  logic [FillW-1:0] fill_r, fill_nxt, fill_base;
  logic [HopW-1:0]  hop_r, hop_nxt, hop_base;
  logic [PtrW-1:0]  wptr_r, slot_gap;
  logic             accept, emit;

  // hold off while the queue is full or the write slot belongs to the oldest frame in work
  assign slot_gap = wptr_r - q_stat.head;
  assign in_stall = q_stat.full | (~q_stat.empty & slot_gap[PtrW-1]);
  assign accept   = in_valid & ~in_stall;

  // fill and hop bookkeeping
  always_comb begin
    fill_base = in_item.restart ? '0 : fill_r;
    hop_base  = in_item.restart ? '0 : hop_r;
    emit      = 1'b0;
    fill_nxt  = fill_base;
    hop_nxt   = hop_base;
    if (fill_base < FillW'(FrameLen)) begin
      fill_nxt = fill_base + 1'b1;
      if (fill_nxt == FillW'(FrameLen)) begin
        emit    = 1'b1;
        hop_nxt = '0;
      end
    end else begin
      hop_nxt = hop_base + 1'b1;
      if (hop_nxt >= HopW'(HopLen)) begin
        emit    = 1'b1;
        hop_nxt = '0;
      end
    end
  end

  assign push        = accept & emit;
  assign push_ptr    = wptr_r + 1'b1;
  assign mem_wr.en   = accept;
  assign mem_wr.addr = wptr_r;
  assign mem_wr.data = in_item.sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      hop_r  <= '0;
      wptr_r <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
      hop_r  <= hop_nxt;
      wptr_r <= wptr_r + 1'b1;
    end
  end

endmodule

// File: rtl/spg_queue.sv
// Two-entry queue of frame end pointers between front and back ends.
module spg_queue import spg_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  logic [PtrW-1:0] push_ptr,
  input  logic            pop,
  output q_stat_t         q_stat
);

  logic [PtrW-1:0] ent_r [2];
  logic            rd_r, wr_r;
  logic [1:0]      cnt_r;

  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);
  assign q_stat.head  = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_r] <= push_ptr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: rtl/spg_back.sv
// Back end: windowed DFT over stored frames, one bin at a time, power output.
module spg_back import spg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  mem_wr_t   mem_wr,
  input  q_stat_t   q_stat,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  back_state_t state_r, state_nxt;

  logic signed [SampleW-1:0] smem [MemDepth];
  logic signed [SampleW-1:0] rd_data_r;
  logic [PtrW-1:0]           rd_addr;

  logic [BinW-1:0] k_r;
  logic [IdxW-1:0] n_r, m_r, n1_r, m1_r, m2_r, m3_r;
  logic            v1_r, v2_r, v3_r, v4_r;

  logic signed [P1W-1:0]  p1_r;
  logic signed [P1W:0]    p1_rnd;
  logic signed [XW-1:0]   x_r;
  logic signed [PrW-1:0]  pr_r, pi_r;
  logic signed [AccW-1:0] acc_re_r, acc_im_r, re_rnd, im_rnd;
  logic signed [ReW-1:0]  re, im;
  logic [SqW-1:0]         sq_re_r, sq_im_r;
  logic [SqW:0]           pw_sum;
  logic [PowerW-1:0]      pw_r;

  logic issue, acc_clr, load_out, out_free, last_n, last_k, pipe_busy;

  assign out_free  = ~out_valid | ~out_stall;
  assign last_n    = (n_r == IdxW'(FrameLen - 1));
  assign last_k    = (k_r == BinW'(NumBins - 1));
  assign pipe_busy = v1_r | v2_r | v3_r | v4_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:  if (!q_stat.empty) state_nxt = BK_RUN;
      BK_RUN:   if (last_n) state_nxt = BK_DRAIN;
      BK_DRAIN: if (!pipe_busy) state_nxt = BK_FIN1;
      BK_FIN1:  state_nxt = BK_FIN2;
      BK_FIN2:  state_nxt = BK_OUT;
      BK_OUT:   if (out_free) state_nxt = last_k ? BK_IDLE : BK_RUN;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    issue    = 1'b0;
    acc_clr  = 1'b0;
    load_out = 1'b0;
    pop      = 1'b0;
    unique case (state_r)
      BK_IDLE: acc_clr = 1'b1;
      BK_RUN:  issue = 1'b1;
      BK_FIN2: acc_clr = 1'b1;
      BK_OUT: begin
        load_out = out_free;
        pop      = out_free & last_k;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else        state_r <= state_nxt;
  end

  // sample memory: front writes, this unit reads the frame before the end pointer
  assign rd_addr = q_stat.head - PtrW'(FrameLen) + PtrW'(n_r);

  always_ff @(posedge clk) begin
    if (mem_wr.en) smem[mem_wr.addr] <= mem_wr.data;
    rd_data_r <= smem[rd_addr];
  end

  // bin and sample counters; twiddle index steps by k each sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
      n_r <= '0;
      m_r <= '0;
    end else if (state_r == BK_IDLE) begin
      k_r <= '0;
      n_r <= '0;
      m_r <= '0;
    end else if (issue) begin
      n_r <= n_r + 1'b1;
      m_r <= m_r + IdxW'(k_r);
    end else if (load_out) begin
      k_r <= last_k ? '0 : k_r + 1'b1;
      n_r <= '0;
      m_r <= '0;
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // window, round, twiddle multiply
  assign p1_rnd = {p1_r[P1W-1], p1_r} + (P1W+1)'(32768);

  always_ff @(posedge clk) begin
    n1_r <= n_r;
    m1_r <= m_r;
    m2_r <= m1_r;
    m3_r <= m2_r;
    p1_r <= P1W'(rd_data_r * $signed({1'b0, WinRom[n1_r]}));
    x_r  <= XW'(p1_rnd >>> 16);
    pr_r <= PrW'(x_r * TwCos[m3_r]);
    pi_r <= PrW'(x_r * TwSin[m3_r]);
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (acc_clr) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (v4_r) begin
      acc_re_r <= acc_re_r + AccW'(pr_r);
      acc_im_r <= acc_im_r - AccW'(pi_r);
    end
  end

  // round to integer, square, sum with saturation
  assign re_rnd = acc_re_r + AccW'(16384);
  assign im_rnd = acc_im_r + AccW'(16384);
  assign re     = ReW'(re_rnd >>> 15);
  assign im     = ReW'(im_rnd >>> 15);
  assign pw_sum = {1'b0, sq_re_r} + {1'b0, sq_im_r};

  always_ff @(posedge clk) begin
    if (state_r == BK_FIN1) begin
      sq_re_r <= SqW'(re * re);
      sq_im_r <= SqW'(im * im);
    end
    if (state_r == BK_FIN2) begin
      pw_r <= (pw_sum > (SqW+1)'(PowerMax)) ? PowerMax : PowerW'(pw_sum);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item.bin      <= k_r;
      out_item.power    <= pw_r;
      out_item.last_bin <= last_k;
    end
  end

endmodule

// File: rtl/spg_checker.sv
// Port-level checks of the spectrogram top level, bound to it.
module spg_checker import spg_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // last flag only on the top bin
  a_last_bin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.last_bin == (out_item.bin == BinW'(NumBins - 1))))
    else $error("last_bin does not match bin index");

  // power never exceeds the saturation value
  a_power_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.power <= PowerMax)
    else $error("power above saturation");

  // bins within a frame come in ascending order
  a_bin_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_item.last_bin ##1 out_valid && !$stable(out_item)
      |-> out_item.bin == $past(out_item.bin) + 1'b1)
    else $error("bin out of order");

endmodule

bind stft_power_spectrogram_top spg_checker u_spg_checker (.*);

// File: dv/testbench.sv
// Self-checking testbench for the STFT power spectrogram block.
`timescale 1ns / 1ps

module testbench;
  import spg_pkg::*;

  localparam int NumItems   = 370;
  localparam int HoldCycles = 4000;

  // Expected-spectrum store with its own copy of the frame state
  class spectrum_board;
    out_item_t    pending_bins[$];
    int           errors;
    int           frames;
    int           checked;
    longint       frame_buf[FrameLen];
    int           fill;
    int           hop;
    longint       hamming[FrameLen];
    longint       cos_q15[FrameLen];
    longint       sin_q15[FrameLen];

    function new();
      longint c, s, w;
      errors = 0;
      frames = 0;
      checked = 0;
      fill = 0;
      hop = 0;
      foreach (frame_buf[i]) frame_buf[i] = 0;
      for (int i = 0; i < FrameLen; i++) begin
        turn(i, FrameLen - 1, c, s);
        w = (54 * Q30One - 46 * c + 50 * 64'sd16384) / (100 * 64'sd16384);
        if (w > 65535) w = 65535;
        if (w < 0) w = 0;
        hamming[i] = w;
        turn(i, FrameLen, c, s);
        cos_q15[i] = sat_q15(c);
        sin_q15[i] = sat_q15(s);
      end
    endfunction

    // first-octant series for cos and sin in Q2.30
    static function void series(input longint phi, output longint c, output longint s);
      longint x2, tc, ts;
      x2 = (phi * phi) / Q30One;
      tc = Q30One;
      ts = phi;
      c = 0;
      s = 0;
      for (int k = 1; k <= 10; k++) begin
        c += tc;
        s += ts;
        tc = -((tc * x2) / Q30One) / longint'((2 * k - 1) * (2 * k));
        ts = -((ts * x2) / Q30One) / longint'((2 * k) * (2 * k + 1));
      end
    endfunction

    // cos and sin of 2 pi p / q via octant folding
    static function void turn(input int p, input int q, output longint co, output longint si);
      int t, oct, r, a;
      longint c, s;
      t = p % q;
      oct = (8 * t) / q;
      r = 8 * t - oct * q;
      a = (oct % 2 == 1) ? (q - r) : r;
      series((longint'(a) * Pi4Q30) / q, c, s);
      case (oct % 8)
        0: begin co = c;  si = s;  end
        1: begin co = s;  si = c;  end
        2: begin co = -s; si = c;  end
        3: begin co = -c; si = s;  end
        4: begin co = -c; si = -s; end
        5: begin co = -s; si = -c; end
        6: begin co = s;  si = -c; end
        default: begin co = c; si = -s; end
      endcase
    endfunction

    static function longint sat_q15(input longint v);
      longint r;
      r = (v + Q30One + 16384) / 32768 - 32768;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r;
    endfunction

    // round half up after dividing by 2^sh, floor semantics
    static function longint rnd_shift(input longint v, input int sh);
      longint d, t;
      d = 64'sd1 << sh;
      t = v + d / 2;
      if (t >= 0) return t / d;
      return -((-t + d - 1) / d);
    endfunction

    function void report(input string what);
      errors++;
      $display("mismatch @%0t: %s", $time, what);
    endfunction

    // accepted sample: update frame state, queue a spectrum when one is due
    function void note_sample(input in_item_t it);
      longint x[FrameLen];
      longint acc_re, acc_im, re, im, pw;
      bit emit;
      out_item_t o;
      emit = 0;
      if (it.restart) begin
        fill = 0;
        hop = 0;
      end
      for (int i = 0; i < FrameLen - 1; i++) frame_buf[i] = frame_buf[i + 1];
      frame_buf[FrameLen - 1] = longint'(it.sample);
      if (fill < FrameLen) begin
        fill++;
        if (fill == FrameLen) begin
          emit = 1;
          hop = 0;
        end
      end else begin
        hop++;
        if (hop >= HopLen) begin
          emit = 1;
          hop = 0;
        end
      end
      if (!emit) return;
      frames++;
      for (int n = 0; n < FrameLen; n++) x[n] = rnd_shift(frame_buf[n] * hamming[n], 16);
      for (int k = 0; k < NumBins; k++) begin
        acc_re = 0;
        acc_im = 0;
        for (int n = 0; n < FrameLen; n++) begin
          acc_re += x[n] * cos_q15[(k * n) % FrameLen];
          acc_im -= x[n] * sin_q15[(k * n) % FrameLen];
        end
        re = rnd_shift(acc_re, 15);
        im = rnd_shift(acc_im, 15);
        pw = re * re + im * im;
        if (pw > (64'sd1 << 42)) pw = 64'sd1 << 42;
        o.bin = BinW'(k);
        o.power = PowerW'(pw);
        o.last_bin = (k == NumBins - 1);
        pending_bins = {pending_bins, o};
      end
    endfunction

    function void check_bin(input out_item_t got);
      out_item_t want;
      checked++;
      if (pending_bins.size() == 0) begin
        report($sformatf("unexpected bin %0d power %0d", got.bin, got.power));
        return;
      end
      want = pending_bins.pop_front();
      if (got.bin !== want.bin)
        report($sformatf("bin got %0d want %0d", got.bin, want.bin));
      if (got.power !== want.power)
        report($sformatf("bin %0d power got %0d want %0d", want.bin, got.power, want.power));
      if (got.last_bin !== want.last_bin)
        report($sformatf("bin %0d last_bin got %0b want %0b", want.bin, got.last_bin,
                         want.last_bin));
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  spectrum_board board;
  int  send_idle;
  int  recv_idle;
  bit  hold_req;
  int  sent;

  stft_power_spectrogram_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    send_idle = 0;
    recv_idle = 0;
    hold_req = 0;
    sent = 0;
  end

  // Result side: random stall, or one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_bin(out_item);
  end

  // Offer one sample; return once the block takes it
  task automatic send_sample(input logic signed [SampleW-1:0] s, input logic rs);
    in_item_t it;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    it.sample = s;
    it.restart = rs;
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    board.note_sample(it);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_bins.size() != 0) @(posedge clk);
  endtask

  // Random samples in runs of one shape: noise, full-scale square wave, rails, small values
  task automatic send_random(input int count);
    int shape;
    logic signed [SampleW-1:0] s;
    shape = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 32 == 0) shape = $urandom_range(4);
      case (shape)
        0, 1: s = SampleW'($urandom);
        2: s = (i % 2) ? 16'sh7fff : 16'sh8000;
        3: s = ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
        default: s = SampleW'($signed($urandom_range(8)) - 4);
      endcase
      send_sample(s, ($urandom_range(59) == 0));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: rails, zero, bit walks, and a restart part way into a frame
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(-16'sd1, 1'b0);
    for (int b = 0; b < SampleW; b++) send_sample(16'sd1 <<< b, 1'b0);
    send_sample(16'sh5555, 1'b1);
    send_sample(16'shaaaa, 1'b0);
    send_sample(16'sh7fff, 1'b1);

    // sender lightly idle, receiver heavily idle
    send_idle = 24;
    recv_idle = 77;
    send_random(150);
    drain();

    // the other way round, with a long receiver hold-off part way through
    send_idle = 77;
    recv_idle = 24;
    send_random(50);
    send_idle = 0;
    hold_req = 1;
    send_random(100);
    send_idle = 77;
    send_random(20);
    drain();

    // no idling
    send_idle = 0;
    recv_idle = 0;
    send_random(NumItems - sent);
    drain();
    repeat (300) @(posedge clk);

    if (board.pending_bins.size() != 0)
      board.report($sformatf("%0d bins never arrived", board.pending_bins.size()));
    $display("covered %0d samples, %0d spectra, %0d bins checked", sent, board.frames,
             board.checked);
    $display("rails, square waves, noise, restarts and a long output hold-off exercised");
    if (board.errors == 0) begin
      $display("[stft_power_spectrogram_top] OK");
    end else begin
      $display("[stft_power_spectrogram_top] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8ms;
    $display("timeout");
    $display("[stft_power_spectrogram_top] ERROR");
    $finish;
  end

endmodule
